// ===== rtl/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared constants and types for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int DEPTH      = 16;
  localparam int KEY_BITS   = 32;
  localparam int FIELD_BITS = 32;
  localparam int VALUE_BITS = 32;
  localparam int TAG_BITS   = (KEY_BITS < FIELD_BITS) ? KEY_BITS : FIELD_BITS;
  localparam int SLOT_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS   = $clog2(DEPTH + 1);
  localparam int CAP_BITS   = 5;
  localparam int CMP_BITS   = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  typedef struct packed {
    logic                  hit;
    logic [DEPTH-1:0]      hit_sel;
    logic [VALUE_BITS-1:0] hit_value;
    logic [DEPTH-1:0]      victim_sel;
    logic [TAG_BITS-1:0]   victim_tag;
    logic [VALUE_BITS-1:0] victim_value;
  } lkv_probe_t;

  typedef struct packed {
    logic                  en;
    logic                  append;
    logic [DEPTH-1:0]      sel;
    logic                  wr_key;
    logic                  wr_value;
    logic [TAG_BITS-1:0]   tag;
    logic [VALUE_BITS-1:0] value;
  } lkv_update_t;

endpackage

// ===== rtl/lkv_match.sv =====
// ----------------------------------------------------------------------------
// lkv_match
// Parallel key compare over all slots; picks the hit and the oldest entry.
// ----------------------------------------------------------------------------
module lkv_match (
  input  logic [lkv_pkg::TAG_BITS-1:0]   tag,
  input  logic [lkv_pkg::TAG_BITS-1:0]   keys   [lkv_pkg::DEPTH],
  input  logic [lkv_pkg::VALUE_BITS-1:0] values [lkv_pkg::DEPTH],
  input  logic [lkv_pkg::SLOT_BITS-1:0]  ages   [lkv_pkg::DEPTH],
  input  logic [lkv_pkg::CNT_BITS-1:0]   count,
  output lkv_pkg::lkv_probe_t            probe
);

  logic [lkv_pkg::DEPTH-1:0] valid;

  always_comb begin
    probe = '0;
    for (int i = 0; i < lkv_pkg::DEPTH; i++) begin
      valid[i]            = lkv_pkg::CNT_BITS'(i) < count;
      probe.hit_sel[i]    = valid[i] && (keys[i] == tag);
      probe.victim_sel[i] = valid[i] && (ages[i] == '0);
      probe.hit_value     = probe.hit_value
                          | ({lkv_pkg::VALUE_BITS{probe.hit_sel[i]}} & values[i]);
      probe.victim_tag    = probe.victim_tag
                          | ({lkv_pkg::TAG_BITS{probe.victim_sel[i]}} & keys[i]);
      probe.victim_value  = probe.victim_value
                          | ({lkv_pkg::VALUE_BITS{probe.victim_sel[i]}} & values[i]);
    end
    probe.hit = |probe.hit_sel;
  end

endmodule

// ===== rtl/lkv_store.sv =====
// ----------------------------------------------------------------------------
// lkv_store
// Slot contents, per-slot recency rank (0 = least recent) and entry count.
// ----------------------------------------------------------------------------
module lkv_store (
  input  logic                           clk,
  input  logic                           rst,
  input  lkv_pkg::lkv_update_t           upd,
  output logic [lkv_pkg::TAG_BITS-1:0]   keys   [lkv_pkg::DEPTH],
  output logic [lkv_pkg::VALUE_BITS-1:0] values [lkv_pkg::DEPTH],
  output logic [lkv_pkg::SLOT_BITS-1:0]  ages   [lkv_pkg::DEPTH],
  output logic [lkv_pkg::CNT_BITS-1:0]   count
);

  logic [lkv_pkg::SLOT_BITS-1:0] ages_next [lkv_pkg::DEPTH];
  logic [lkv_pkg::SLOT_BITS-1:0] sel_age;
  logic [lkv_pkg::SLOT_BITS-1:0] last_rank;
  logic [lkv_pkg::CNT_BITS-1:0]  count_m1;
  logic [lkv_pkg::CNT_BITS-1:0]  count_next;

  always_comb begin
    count_m1  = count - lkv_pkg::CNT_BITS'(1);
    last_rank = count_m1[lkv_pkg::SLOT_BITS-1:0];
    sel_age   = '0;
    for (int i = 0; i < lkv_pkg::DEPTH; i++) begin
      sel_age = sel_age | ({lkv_pkg::SLOT_BITS{upd.sel[i]}} & ages[i]);
    end
    count_next = count;
    for (int i = 0; i < lkv_pkg::DEPTH; i++) begin
      ages_next[i] = ages[i];
      if (upd.en) begin
        if (upd.append) begin
          if (upd.sel[i]) begin
            ages_next[i] = count[lkv_pkg::SLOT_BITS-1:0];
          end
        end else if (upd.sel[i]) begin
          ages_next[i] = last_rank;
        end else if ((lkv_pkg::CNT_BITS'(i) < count) && (ages[i] > sel_age)) begin
          ages_next[i] = ages[i] - lkv_pkg::SLOT_BITS'(1);
        end
      end
    end
    if (upd.en && upd.append) begin
      count_next = count + lkv_pkg::CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < lkv_pkg::DEPTH; i++) begin
      ages[i] <= ages_next[i];
      if (upd.en && upd.sel[i] && upd.wr_key) begin
        keys[i] <= upd.tag;
      end
      if (upd.en && upd.sel[i] && upd.wr_value) begin
        values[i] <= upd.value;
      end
    end
  end

endmodule

// ===== rtl/lru_key_value_cache_core.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A request (func, key, value) is taken on a clock edge with start high and
// busy low. busy stays low: a request may be issued every cycle.
// func lookup returns hit and found_value and refreshes the entry on a hit.
// func insert writes the value as most recent; a new key with the cache at
// capacity evicts the oldest entry and reports it on evicted, evicted_key and
// evicted_value.
// Each request gives one result, shown on the result ports for one cycle
// with done high from the edge after the request is taken (the compare and
// update pass runs from the input register into the result register).
// Throughput is one request per cycle, set by the parallel compare over all
// slots. The receiver cannot stall; results must be taken when done is high.
// Write capacity through wr_en/wr_data only while no request is in flight;
// the block does not enforce this. Synchronous reset empties the cache, drops
// any request in flight and sets capacity to 16. No clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              func,
  input  logic [lkv_pkg::FIELD_BITS-1:0]    key,
  input  logic [lkv_pkg::VALUE_BITS-1:0]    value,
  input  logic                              wr_en,
  input  logic [lkv_pkg::CAP_BITS-1:0]      wr_data,
  output logic                              done,
  output logic                              hit,
  output logic [lkv_pkg::VALUE_BITS-1:0]    found_value,
  output logic                              evicted,
  output logic [lkv_pkg::FIELD_BITS-1:0]    evicted_key,
  output logic [lkv_pkg::VALUE_BITS-1:0]    evicted_value
);

  logic                            in_valid;
  logic                            in_func;
  logic [lkv_pkg::TAG_BITS-1:0]    in_tag;
  logic [lkv_pkg::VALUE_BITS-1:0]  in_value;
  logic [lkv_pkg::CAP_BITS-1:0]    capacity;

  logic [lkv_pkg::TAG_BITS-1:0]    keys   [lkv_pkg::DEPTH];
  logic [lkv_pkg::VALUE_BITS-1:0]  values [lkv_pkg::DEPTH];
  logic [lkv_pkg::SLOT_BITS-1:0]   ages   [lkv_pkg::DEPTH];
  logic [lkv_pkg::CNT_BITS-1:0]    count;

  lkv_pkg::lkv_probe_t             probe;
  lkv_pkg::lkv_update_t            upd;

  logic [lkv_pkg::CMP_BITS-1:0]    cap_w;
  logic [lkv_pkg::CMP_BITS-1:0]    cnt_w;
  logic [lkv_pkg::CMP_BITS-1:0]    eff_w;
  logic                            full;
  logic [lkv_pkg::DEPTH-1:0]       append_sel;

  logic                            hit_next;
  logic [lkv_pkg::VALUE_BITS-1:0]  found_value_next;
  logic                            evicted_next;
  logic [lkv_pkg::FIELD_BITS-1:0]  evicted_key_next;
  logic [lkv_pkg::VALUE_BITS-1:0]  evicted_value_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      capacity <= lkv_pkg::CAP_RESET;
      done     <= 1'b0;
    end else begin
      in_valid <= start && !busy;
      done     <= in_valid;
      if (wr_en) begin
        capacity <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_func  <= func;
      in_tag   <= key[lkv_pkg::TAG_BITS-1:0];
      in_value <= value;
    end
    hit           <= hit_next;
    found_value   <= found_value_next;
    evicted       <= evicted_next;
    evicted_key   <= evicted_key_next;
    evicted_value <= evicted_value_next;
  end

  lkv_match u_match (
    .tag    (in_tag),
    .keys   (keys),
    .values (values),
    .ages   (ages),
    .count  (count),
    .probe  (probe)
  );

  lkv_store u_store (
    .clk    (clk),
    .rst    (rst),
    .upd    (upd),
    .keys   (keys),
    .values (values),
    .ages   (ages),
    .count  (count)
  );

  always_comb begin
    cap_w = lkv_pkg::CMP_BITS'(capacity);
    cnt_w = lkv_pkg::CMP_BITS'(count);
    if (cap_w == '0) begin
      eff_w = lkv_pkg::CMP_BITS'(1);
    end else if (cap_w > lkv_pkg::CMP_BITS'(lkv_pkg::DEPTH)) begin
      eff_w = lkv_pkg::CMP_BITS'(lkv_pkg::DEPTH);
    end else begin
      eff_w = cap_w;
    end
    full = cnt_w >= eff_w;
    for (int i = 0; i < lkv_pkg::DEPTH; i++) begin
      append_sel[i] = lkv_pkg::CNT_BITS'(i) == count;
    end

    upd                = '0;
    upd.tag            = in_tag;
    upd.value          = in_value;
    hit_next           = 1'b0;
    found_value_next   = '0;
    evicted_next       = 1'b0;
    evicted_key_next   = '0;
    evicted_value_next = '0;

    if (in_valid) begin
      case (in_func)
        lkv_pkg::FUNC_LOOKUP: begin
          if (probe.hit) begin
            upd.en           = 1'b1;
            upd.sel          = probe.hit_sel;
            hit_next         = 1'b1;
            found_value_next = probe.hit_value;
          end
        end
        lkv_pkg::FUNC_INSERT: begin
          upd.en       = 1'b1;
          upd.wr_value = 1'b1;
          if (probe.hit) begin
            upd.sel = probe.hit_sel;
          end else if (!full) begin
            upd.append = 1'b1;
            upd.sel    = append_sel;
            upd.wr_key = 1'b1;
          end else begin
            upd.sel            = probe.victim_sel;
            upd.wr_key         = 1'b1;
            evicted_next       = 1'b1;
            evicted_key_next   = lkv_pkg::FIELD_BITS'(probe.victim_tag);
            evicted_value_next = probe.victim_value;
          end
        end
        default: begin
          upd.en = 1'b0;
        end
      endcase
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("request without result");

  a_hit_xor_evict: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && evicted))
    else $error("hit and eviction in one result");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !evicted) |-> (evicted_key == '0) && (evicted_value == '0))
    else $error("eviction fields not zero");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= lkv_pkg::CNT_BITS'(lkv_pkg::DEPTH)))
    else $error("entry count above depth");

  a_evict_when_full: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !full) |=> !evicted)
    else $error("eviction with free slot");

endmodule
